FILE: rtl/sdd_pkg.sv
// types and constants for the satellite delivery descriptor decoder
// shared by sdd_weigh, sdd_scale and sat_delivery_descriptor_decode
package sdd_pkg;

	localparam int unsigned SUM_W = 28;
	localparam int unsigned POS_W = 15;
	localparam int unsigned QUO_W = 18;
	localparam int unsigned RECIP_W = 29;
	localparam int unsigned PROD_W = SUM_W + RECIP_W;

	localparam logic [23:0] POW10 [8] = '{
		24'd1, 24'd10, 24'd100, 24'd1000,
		24'd10000, 24'd100000, 24'd1000000, 24'd10000000
	};

	// limits seen on the sums that are already divided by ten
	localparam logic [SUM_W-1:0] FREQ_LIMIT_DIV10 = 28'd10000000;
	localparam logic [SUM_W-1:0] RATE_LIMIT_DIV10 = 28'd5000000;
	localparam logic [SUM_W-1:0] DEC_SCALE = 28'd10;
	localparam logic [SUM_W-1:0] ROUND_HALF = 28'd500;
	localparam logic [SUM_W-1:0] KHZ_STEP = 28'd1000;
	localparam logic [SUM_W-1:0] FREQ_MAX = 28'd166667000;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
	localparam int unsigned RECIP_SHIFT = 38;

	localparam logic [1:0] ROLLOFF_035 = 2'd0;
	localparam logic SYS_DVBS = 1'b0;

	typedef struct packed {
		logic [31:0] freq_bcd;
		logic [15:0] position_bcd;
		logic [7:0]  flag_byte;
		logic [27:0] rate_bcd;
		logic [3:0]  fec_nibble;
	} sdd_in_t;

	typedef struct packed {
		logic [27:0] frequency_khz;
		logic [14:0] orbital_position;
		logic        delivery_system;
		logic [1:0]  modulation;
		logic [1:0]  rolloff_code;
		logic [1:0]  polarization;
		logic [27:0] rate_sps;
		logic [3:0]  fec_code;
	} sdd_out_t;

	typedef struct packed {
		logic        sys;
		logic [1:0]  modu;
		logic [1:0]  roll;
		logic [1:0]  pol;
		logic [3:0]  fec;
	} sdd_flags_t;

	typedef struct packed {
		logic [SUM_W-1:0] freq_div10;
		logic [POS_W-1:0] pos;
		logic [SUM_W-1:0] rate_div10;
		sdd_flags_t       flags;
	} sdd_sum_t;

	typedef struct packed {
		logic [QUO_W-1:0] freq_mhz;
		logic [POS_W-1:0] pos;
		logic [SUM_W-1:0] rate;
		sdd_flags_t       flags;
	} sdd_scl_t;

endpackage

FILE: rtl/sdd_weigh.sv
// weighted nibble sums and flag decode of one descriptor body
// depends on sdd_pkg
module sdd_weigh (
	input  sdd_pkg::sdd_in_t  desc,
	output sdd_pkg::sdd_sum_t sums
);
	import sdd_pkg::*;

	logic [SUM_W-1:0] freq_acc;
	logic [SUM_W-1:0] rate_acc;
	logic [POS_W-1:0] pos_acc;

	// frequency weights 10^1..10^8 and rate weights 10^2..10^8 both drop one decade
	always_comb begin
		freq_acc = '0;
		for (int i = 0; i < 8; i++) begin
			freq_acc = freq_acc + SUM_W'(desc.freq_bcd[4*i +: 4]) * SUM_W'(POW10[i]);
		end
		rate_acc = '0;
		for (int i = 0; i < 7; i++) begin
			rate_acc = rate_acc + SUM_W'(desc.rate_bcd[4*i +: 4]) * SUM_W'(POW10[i+1]);
		end
		pos_acc = '0;
		for (int i = 0; i < 4; i++) begin
			pos_acc = pos_acc + POS_W'(desc.position_bcd[4*i +: 4]) * POS_W'(POW10[i]);
		end
	end

	always_comb begin
		sums.freq_div10 = freq_acc;
		sums.rate_div10 = rate_acc;
		sums.pos = pos_acc;
		sums.flags.sys = desc.flag_byte[2];
		sums.flags.modu = desc.flag_byte[1:0];
		sums.flags.roll = (desc.flag_byte[2] == SYS_DVBS) ? ROLLOFF_035 : desc.flag_byte[4:3];
		sums.flags.pol = desc.flag_byte[6:5];
		sums.flags.fec = desc.fec_nibble;
	end

endmodule

FILE: rtl/sdd_scale.sv
// range workaround and whole-mhz quotient by reciprocal multiply
// depends on sdd_pkg
module sdd_scale (
	input  sdd_pkg::sdd_sum_t sums,
	output sdd_pkg::sdd_scl_t scl
);
	import sdd_pkg::*;

	logic [SUM_W-1:0]  freq_khz;
	logic [SUM_W-1:0]  freq_rnd;
	logic [PROD_W-1:0] prod;

	always_comb begin
		if (sums.freq_div10 >= FREQ_LIMIT_DIV10) begin
			freq_khz = sums.freq_div10;
		end else begin
			freq_khz = sums.freq_div10 * DEC_SCALE;
		end
		freq_rnd = freq_khz + ROUND_HALF;
		prod = PROD_W'(freq_rnd) * PROD_W'(RECIP_1000);
		scl.freq_mhz = prod[RECIP_SHIFT +: QUO_W];
		if (sums.rate_div10 >= RATE_LIMIT_DIV10) begin
			scl.rate = sums.rate_div10;
		end else begin
			scl.rate = sums.rate_div10 * DEC_SCALE;
		end
		scl.pos = sums.pos;
		scl.flags = sums.flags;
	end

endmodule

FILE: rtl/sat_delivery_descriptor_decode.sv
// satellite delivery descriptor decoder, top level with the pipeline registers
// depends on sdd_pkg, sdd_weigh and sdd_scale
//
//   port    valid        stall        payload
//   desc    desc_valid   desc_stall   desc  (sdd_in_t, descriptor body)
//   tune    tune_valid   tune_stall   tune  (sdd_out_t, decoded tuning)
//
// one request per cycle unless the pipeline is full under tune_stall, passing through
// four registers: input register, nibble sums, reciprocal multiply for the mhz
// rounding, result
// each stage moves when it is empty or the next one moves, so bubbles close up
// under a stall; reset empties all stages
module sat_delivery_descriptor_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              desc_valid,
	output logic              desc_stall,
	input  sdd_pkg::sdd_in_t  desc,
	output logic              tune_valid,
	input  logic              tune_stall,
	output sdd_pkg::sdd_out_t tune
);
	import sdd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	sdd_in_t  desc_s1;
	sdd_sum_t sums;
	sdd_sum_t sums_s2;
	sdd_scl_t scl;
	sdd_scl_t scl_s3;
	sdd_out_t tune_s4;

	assign adv_s4 = !v_s4 || !tune_stall;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign desc_stall = !adv_s1;

	sdd_weigh u_weigh (
		.desc (desc_s1),
		.sums (sums)
	);

	sdd_scale u_scale (
		.sums (sums_s2),
		.scl  (scl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= desc_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) desc_s1 <= desc;
		if (adv_s2) sums_s2 <= sums;
		if (adv_s3) scl_s3 <= scl;
		if (adv_s4) begin
			tune_s4.frequency_khz <= SUM_W'(scl_s3.freq_mhz) * KHZ_STEP;
			tune_s4.orbital_position <= scl_s3.pos;
			tune_s4.delivery_system <= scl_s3.flags.sys;
			tune_s4.modulation <= scl_s3.flags.modu;
			tune_s4.rolloff_code <= scl_s3.flags.roll;
			tune_s4.polarization <= scl_s3.flags.pol;
			tune_s4.rate_sps <= scl_s3.rate;
			tune_s4.fec_code <= scl_s3.flags.fec;
		end
	end

	assign tune_valid = v_s4;
	assign tune = tune_s4;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		desc_valid && !desc_stall |=> v_s1)
		else $error("accepted request did not enter the input register");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && tune_stall |-> desc_stall)
		else $error("full pipeline under stall still takes requests");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		tune_valid && !tune_stall && !v_s3 |=> !tune_valid)
		else $error("result repeated after it was taken");

	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		tune_valid |-> tune.frequency_khz <= FREQ_MAX)
		else $error("rounded frequency out of range");

endmodule

FILE: dv/sat_delivery_descriptor_decode_tb.sv
// testbench for sat_delivery_descriptor_decode: directed and random descriptors
// with random idling on both sides, checked against an in-bench decode
// depends on sdd_pkg and the sat_delivery_descriptor_decode rtl
module sat_delivery_descriptor_decode_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdd_pkg::*;

	localparam int unsigned FREQ_DIV_AT = 100000000;
	localparam int unsigned RATE_DIV_AT = 50000000;
	localparam int unsigned ROUND_HALF_KHZ = 500;
	localparam int unsigned MHZ_KHZ = 1000;
	localparam int unsigned DECADE = 10;
	localparam int unsigned FREQ_LOW_WEIGHT = 10;
	localparam int unsigned POS_LOW_WEIGHT = 1;
	localparam int unsigned RATE_LOW_WEIGHT = 100;
	localparam int unsigned FREQ_DIGITS = 8;
	localparam int unsigned POS_DIGITS = 4;
	localparam int unsigned RATE_DIGITS = 7;
	localparam int unsigned MAX_IDLE = 7;
	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned PRINT_LIMIT = 100;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_HALF = 1000;
	localparam int unsigned BURST_LEN = 16;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     desc_valid = 1'b0;
	logic     desc_stall;
	sdd_in_t  desc = '0;
	logic     tune_valid;
	logic     tune_stall = 1'b0;
	sdd_out_t tune;

	sdd_out_t pending_tunings[$];
	sdd_out_t tuning_want;
	int       mismatch_count = 0;
	int       idle_cycles = 0;
	int       rx_hold = 0;
	bit       tx_quiet = 1'b0;
	bit       rx_quiet = 1'b0;

	sat_delivery_descriptor_decode dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (desc_valid),
		.desc_stall (desc_stall),
		.desc       (desc),
		.tune_valid (tune_valid),
		.tune_stall (tune_stall),
		.tune       (tune)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [31:0] bcd_sum(logic [31:0] nibbles, int unsigned digits,
			logic [31:0] low_weight);
		logic [31:0] sum;
		logic [31:0] weight;
		sum = '0;
		weight = low_weight;
		for (int i = 0; i < digits; i++) begin
			sum += nibbles[4*i +: 4] * weight;
			weight *= DECADE;
		end
		return sum;
	endfunction

	function automatic sdd_out_t decode_tuning(sdd_in_t d);
		sdd_out_t    t;
		logic [31:0] freq;
		logic [31:0] pos;
		logic [31:0] rate;
		freq = bcd_sum(d.freq_bcd, FREQ_DIGITS, FREQ_LOW_WEIGHT);
		pos = bcd_sum({16'd0, d.position_bcd}, POS_DIGITS, POS_LOW_WEIGHT);
		rate = bcd_sum({4'd0, d.rate_bcd}, RATE_DIGITS, RATE_LOW_WEIGHT);
		if (freq >= FREQ_DIV_AT) begin
			freq = freq / DECADE;
		end
		if (rate >= RATE_DIV_AT) begin
			rate = rate / DECADE;
		end
		freq = ((freq + ROUND_HALF_KHZ) / MHZ_KHZ) * MHZ_KHZ;
		t.frequency_khz = freq[27:0];
		t.orbital_position = pos[14:0];
		t.delivery_system = d.flag_byte[2];
		t.modulation = d.flag_byte[1:0];
		t.rolloff_code = (d.flag_byte[2] == SYS_DVBS) ? ROLLOFF_035 : d.flag_byte[4:3];
		t.polarization = d.flag_byte[6:5];
		t.rate_sps = rate[27:0];
		t.fec_code = d.fec_nibble;
		return t;
	endfunction

	function automatic sdd_in_t mk_desc(logic [31:0] freq, logic [15:0] pos, logic [7:0] flags,
			logic [27:0] rate, logic [3:0] fec);
		sdd_in_t d;
		d.freq_bcd = freq;
		d.position_bcd = pos;
		d.flag_byte = flags;
		d.rate_bcd = rate;
		d.fec_nibble = fec;
		return d;
	endfunction

	function automatic logic [31:0] rand_bcd(int unsigned digits);
		logic [31:0] r;
		r = '0;
		for (int i = 0; i < digits; i++) begin
			r[4*i +: 4] = 4'($urandom_range(0, 9));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		end
		mismatch_count++;
	endtask

	// one request, with a random gap ahead of it
	task automatic send_desc(input sdd_in_t d);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			desc_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		desc_valid <= 1'b1;
		desc <= d;
		do @(posedge clk); while (desc_stall);
		pending_tunings.insert(pending_tunings.size(), decode_tuning(d));
	endtask

	task automatic drain_tunings();
		desc_valid <= 1'b0;
		do @(posedge clk); while (pending_tunings.size() != 0);
	endtask

	task automatic test_field_extremes();
		send_desc(mk_desc(32'h0, 16'h0, 8'h00, 28'h0, 4'h0));
		send_desc(mk_desc(32'hFFFFFFFF, 16'hFFFF, 8'hFF, 28'hFFFFFFF, 4'hF));
	endtask

	task automatic test_divide_and_rounding();
		send_desc(mk_desc(32'h10000000, 16'h0130, 8'h04, 28'h0275000, 4'h2));
		send_desc(mk_desc(32'h09999999, 16'h0192, 8'h04, 28'h0275000, 4'h2));
		send_desc(mk_desc(32'h01175000, 16'h0235, 8'h05, 28'h0500000, 4'h3));
		send_desc(mk_desc(32'h01175000, 16'h0235, 8'h05, 28'h0499999, 4'h3));
		send_desc(mk_desc(32'h00000050, 16'h0010, 8'h00, 28'h0000001, 4'h1));
		send_desc(mk_desc(32'h00000049, 16'h0010, 8'h00, 28'h0000001, 4'h1));
		send_desc(mk_desc(32'h10000050, 16'h0282, 8'h06, 28'h0999999, 4'h9));
	endtask

	// rolloff bits are dropped under dvb-s, the west/east bit is ignored
	task automatic test_flag_decoding();
		send_desc(mk_desc(32'h01201500, 16'h0192, 8'h18, 28'h0220000, 4'h5));
		send_desc(mk_desc(32'h01201500, 16'h0192, 8'h04, 28'h0220000, 4'h5));
		send_desc(mk_desc(32'h01201500, 16'h0192, 8'h0D, 28'h0220000, 4'h5));
		send_desc(mk_desc(32'h01201500, 16'h0192, 8'h16, 28'h0220000, 4'h5));
		send_desc(mk_desc(32'h01201500, 16'h0192, 8'h1F, 28'h0220000, 4'h5));
		send_desc(mk_desc(32'h01201500, 16'h0192, 8'h23, 28'h0220000, 4'h5));
		send_desc(mk_desc(32'h01201500, 16'h0192, 8'h40, 28'h0220000, 4'h5));
		send_desc(mk_desc(32'h01201500, 16'h0192, 8'h60, 28'h0220000, 4'h5));
		send_desc(mk_desc(32'h01201500, 16'h0192, 8'hE5, 28'h0220000, 4'h5));
	endtask

	task automatic test_nondecimal_nibbles();
		send_desc(mk_desc(32'hAAAAAAAA, 16'hABCD, 8'h0C, 28'hFEDCBA9, 4'hA));
		send_desc(mk_desc(32'h0000000F, 16'h000F, 8'h81, 28'h000000F, 4'hC));
	endtask

	task automatic make_random_desc(output sdd_in_t d);
		if ($urandom_range(0, 3) == 0) begin
			d.freq_bcd = $urandom;
			d.position_bcd = 16'($urandom_range(0, 16'hFFFF));
			d.rate_bcd = 28'($urandom_range(0, 28'hFFFFFFF));
		end else begin
			d.freq_bcd = rand_bcd(FREQ_DIGITS);
			d.position_bcd = 16'(rand_bcd(POS_DIGITS));
			d.rate_bcd = 28'(rand_bcd(RATE_DIGITS));
		end
		d.flag_byte = 8'($urandom_range(0, 8'hFF));
		d.fec_nibble = 4'($urandom_range(0, 4'hF));
	endtask

	task automatic test_random_traffic(input int unsigned count);
		sdd_in_t d;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			make_random_desc(d);
			send_desc(d);
		end
	endtask

	// back to back burst, then hold off until every result is back
	task automatic test_drain_pause();
		sdd_in_t d;
		tx_quiet = 1'b1;
		for (int n = 0; n < BURST_LEN; n++) begin
			make_random_desc(d);
			send_desc(d);
		end
		drain_tunings();
		tx_quiet = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_divide_and_rounding();
		test_flag_decoding();
		test_nondecimal_nibbles();
		test_random_traffic(RANDOM_HALF);
		test_drain_pause();
		test_random_traffic(RANDOM_HALF);
		drain_tunings();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("sat_delivery_descriptor_decode regression: pass");
		end else begin
			$display("sat_delivery_descriptor_decode regression: fail");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (tune_valid && !tune_stall) begin
			rx_hold = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
		end
		if (rx_hold != 0) begin
			tune_stall <= 1'b1;
			rx_hold--;
		end else begin
			tune_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && tune_valid && !tune_stall) begin
			if (pending_tunings.size() == 0) begin
				report_mismatch("unrequested result", '0, '0);
			end else begin
				tuning_want = pending_tunings.pop_front();
				if (tune.frequency_khz !== tuning_want.frequency_khz)
					report_mismatch("frequency_khz", 32'(tune.frequency_khz),
						32'(tuning_want.frequency_khz));
				if (tune.orbital_position !== tuning_want.orbital_position)
					report_mismatch("orbital_position", 32'(tune.orbital_position),
						32'(tuning_want.orbital_position));
				if (tune.delivery_system !== tuning_want.delivery_system)
					report_mismatch("delivery_system", 32'(tune.delivery_system),
						32'(tuning_want.delivery_system));
				if (tune.modulation !== tuning_want.modulation)
					report_mismatch("modulation", 32'(tune.modulation),
						32'(tuning_want.modulation));
				if (tune.rolloff_code !== tuning_want.rolloff_code)
					report_mismatch("rolloff_code", 32'(tune.rolloff_code),
						32'(tuning_want.rolloff_code));
				if (tune.polarization !== tuning_want.polarization)
					report_mismatch("polarization", 32'(tune.polarization),
						32'(tuning_want.polarization));
				if (tune.rate_sps !== tuning_want.rate_sps)
					report_mismatch("rate_sps", 32'(tune.rate_sps),
						32'(tuning_want.rate_sps));
				if (tune.fec_code !== tuning_want.fec_code)
					report_mismatch("fec_code", 32'(tune.fec_code),
						32'(tuning_want.fec_code));
			end
		end
	end

	always @(posedge clk) begin
		if ((desc_valid && !desc_stall) || (tune_valid && !tune_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sat_delivery_descriptor_decode regression: fail");
			$finish;
		end
	end

endmodule

FILE: filelist.f
rtl/sdd_pkg.sv
rtl/sdd_weigh.sv
rtl/sdd_scale.sv
rtl/sat_delivery_descriptor_decode.sv
dv/sat_delivery_descriptor_decode_tb.sv
